// ===== src/pre_pkg.sv =====
// ---------------------------------------------------------------------------
// Reprojection error package
// Shared widths, command codes and the front-to-back word type.
// ---------------------------------------------------------------------------
package pre_pkg;
    localparam int COORD_BITS_DEF = 32;
    localparam int NCOEF = 12;
    localparam int IDX_W = 4;
    localparam int ERR_W = 48;
    localparam int DIV_BITS = 66;

    typedef enum logic {
        t_cmd_load = 1'b0,
        t_cmd_proj = 1'b1
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] ou;
        logic signed [31:0] ov;
    } t_point;
endpackage

// ===== src/pre_front.sv =====
// ---------------------------------------------------------------------------
// Reprojection error front end
// Accepts words, loads coefficients and passes projection words on.
// ---------------------------------------------------------------------------
module pre_front #(
    parameter int CW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_cmd,
    input  logic [3:0]      i_idx,
    input  logic [31:0]     i_coeff,
    input  logic [CW-1:0]   i_x,
    input  logic [CW-1:0]   i_y,
    input  logic [CW-1:0]   i_z,
    input  logic [CW-1:0]   i_ou,
    input  logic [CW-1:0]   i_ov,
    output logic            o_valid,
    input  logic            i_ready,
    output pre_pkg::t_point o_pt,
    output logic [pre_pkg::NCOEF*32-1:0] o_mat
);
    import pre_pkg::*;
    localparam int NC = NCOEF;

    logic [31:0] r_mat [NC];
    logic [1:0] r_cnt;
    t_point r_q [2];
    logic r_wp, r_rp;
    logic acc, pop;
    logic ld_ok;
    t_point pt;

    // A load word may only pass once every queued point has left for the
    // back end, which reads the matrix as it takes a point.
    assign ld_ok = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign o_ready = (r_cnt != 2'd2) && (t_cmd'(i_cmd) == t_cmd_proj || ld_ok);
    assign acc = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_pt = r_q[r_rp];

    always_comb begin
        pt.x = 32'(signed'(i_x));
        pt.y = 32'(signed'(i_y));
        pt.z = 32'(signed'(i_z));
        pt.ou = 32'(signed'(i_ou));
        pt.ov = 32'(signed'(i_ov));
        for (int k = 0; k < NC; k++) begin
            o_mat[k*32 +: 32] = r_mat[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && t_cmd'(i_cmd) == t_cmd_load && i_idx < IDX_W'(NC)) begin
            r_mat[i_idx] <= i_coeff;
        end
        if (acc && t_cmd'(i_cmd) == t_cmd_proj) begin
            r_q[r_wp] <= pt;
        end
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (acc && t_cmd'(i_cmd) == t_cmd_proj) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(acc && t_cmd'(i_cmd) == t_cmd_proj) - 2'(pop);
        end
    end
endmodule

// ===== src/pre_div.sv =====
// ---------------------------------------------------------------------------
// Reprojection error divider
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ---------------------------------------------------------------------------
module pre_div #(
    parameter int CW = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [49:0] i_num,
    input  logic signed [49:0] i_den,
    output logic [CW-1:0]      o_q
);
    import pre_pkg::*;
    localparam int NB = DIV_BITS;
    localparam int QB = DIV_BITS;

    logic [NB-1:0] r_n [QB+1];
    logic [48:0] r_d [QB+1];
    logic [49:0] r_r [QB+1];
    logic [QB-1:0] r_qq [QB+1];
    logic r_neg [QB+1];
    logic [49:0] an, ad;

    assign an = i_num[49] ? 50'(-i_num) : 50'(i_num);
    assign ad = i_den[49] ? 50'(-i_den) : 50'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= {an[49:0], 16'd0};
            r_d[0] <= ad[48:0];
            r_r[0] <= '0;
            r_qq[0] <= '0;
            r_neg[0] <= i_num[49] ^ i_den[49];
            for (int s = 0; s < QB; s++) begin : st
                logic [50:0] t;
                t = {r_r[s], r_n[s][NB-1]};
                if (t >= {2'd0, r_d[s]}) begin
                    r_r[s+1] <= 50'(t - {2'd0, r_d[s]});
                    r_qq[s+1] <= {r_qq[s][QB-2:0], 1'b1};
                end else begin
                    r_r[s+1] <= t[49:0];
                    r_qq[s+1] <= {r_qq[s][QB-2:0], 1'b0};
                end
                r_n[s+1] <= {r_n[s][NB-2:0], 1'b0};
                r_d[s+1] <= r_d[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // Quotient bits past the top of the dividend shift are the high part.
    logic big;
    logic [QB-1:0] q;
    assign q = r_qq[QB];
    assign big = (q >= (QB'(1) << (CW-1)));
    always_comb begin
        if (r_neg[QB]) begin
            o_q = big ? {1'b1, {(CW-1){1'b0}}} : CW'(-q);
        end else begin
            o_q = big ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
        end
    end
endmodule

// ===== src/pre_back.sv =====
// ---------------------------------------------------------------------------
// Reprojection error back end
// Matrix products, row sums, division pipeline and squared error.
// ---------------------------------------------------------------------------
module pre_back #(
    parameter int CW = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pre_pkg::t_point   i_pt,
    input  logic [12*32-1:0]  i_mat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CW-1:0]     o_u,
    output logic [CW-1:0]     o_v,
    output logic [47:0]       o_err,
    output logic              o_zw
);
    import pre_pkg::*;
    localparam int DL = DIV_BITS + 1;
    localparam int NS = DL + 5;

    logic en;
    logic [NS-1:0] r_vld;
    assign en = !r_vld[NS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NS-1];

    logic signed [63:0] r_p [9];
    logic signed [31:0] r_c3 [3];
    logic signed [49:0] r_s [3];
    logic signed [31:0] r_ou [DL+2], r_ov [DL+2];
    logic r_zw [2:DL+1];
    logic [CW-1:0] qu, qv;

    function automatic logic signed [49:0] fl(input logic signed [63:0] p);
        return 50'(p >>> 16);
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                r_p[r*3]   <= signed'(i_mat[(r*4)*32 +: 32]) * i_pt.x;
                r_p[r*3+1] <= signed'(i_mat[(r*4+1)*32 +: 32]) * i_pt.y;
                r_p[r*3+2] <= signed'(i_mat[(r*4+2)*32 +: 32]) * i_pt.z;
                r_c3[r] <= signed'(i_mat[(r*4+3)*32 +: 32]);
                r_s[r] <= fl(r_p[r*3]) + fl(r_p[r*3+1]) + fl(r_p[r*3+2])
                    + 50'(r_c3[r]);
            end
            r_ou[0] <= i_pt.ou;
            r_ov[0] <= i_pt.ov;
            r_ou[1] <= r_ou[0];
            r_ov[1] <= r_ov[0];
            r_zw[2] <= (r_s[2] == '0);
            for (int k = 2; k < DL+2; k++) begin
                r_ou[k] <= r_ou[k-1];
                r_ov[k] <= r_ov[k-1];
            end
            for (int k = 3; k < DL+2; k++) begin
                r_zw[k] <= r_zw[k-1];
            end
        end
    end

    pre_div #(.CW(CW)) u_du (.i_clk(i_clk), .i_en(en), .i_num(r_s[0]),
        .i_den(r_s[2] == '0 ? 50'sd1 : r_s[2]), .o_q(qu));
    pre_div #(.CW(CW)) u_dv (.i_clk(i_clk), .i_en(en), .i_num(r_s[1]),
        .i_den(r_s[2] == '0 ? 50'sd1 : r_s[2]), .o_q(qv));

    logic [32:0] r_du, r_dv;
    logic [CW-1:0] r_u1, r_v1, r_u2, r_v2, r_u3, r_v3;
    logic [65:0] r_a, r_b;
    logic [66:0] r_sum;
    logic r_z1, r_z2, r_z3;
    logic signed [32:0] du, dv;
    assign du = 33'(signed'(qu)) - 33'(signed'(r_ou[DL+1][CW-1:0]));
    assign dv = 33'(signed'(qv)) - 33'(signed'(r_ov[DL+1][CW-1:0]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_du <= du[32] ? 33'(-du) : 33'(du);
            r_dv <= dv[32] ? 33'(-dv) : 33'(dv);
            r_u1 <= qu; r_v1 <= qv; r_z1 <= r_zw[DL+1];
            r_a <= r_du * r_du;
            r_b <= r_dv * r_dv;
            r_u2 <= r_u1; r_v2 <= r_v1; r_z2 <= r_z1;
            r_sum <= {1'b0, r_a} + {1'b0, r_b};
            r_u3 <= r_u2; r_v3 <= r_v2; r_z3 <= r_z2;
        end
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // Two stages ahead of the divider and three behind it: DL+5 in all.
    assign o_zw = r_z3;
    assign o_u = r_z3 ? '0 : r_u3;
    assign o_v = r_z3 ? '0 : r_v3;
    assign o_err = r_z3 ? '0 : ((r_sum[66:16] > 51'(48'hFFFF_FFFF_FFFF)) ?
        48'hFFFF_FFFF_FFFF : r_sum[63:16]);
endmodule

// ===== src/point_reprojection_error.sv =====
// ---------------------------------------------------------------------------
// Point reprojection error
// Projects 3D points through a stored 3x4 matrix and measures the error.
// ---------------------------------------------------------------------------
// The slave channel takes words of two kinds, chosen by s_axis_tuser. A load
// word writes one matrix coefficient and yields no result. A projection word
// carries a point and an observation and yields one master-side word.
// One word is accepted per cycle while s_axis_tready is high. A front stage
// writes the coefficients and sends projection words into a two-entry queue;
// the back end is a 72-stage pipeline of products, row sums, a 67-stage
// divider for each of u and v, and the squared error.
// A load word waits while projection words sit in the queue, unless the last
// of them leaves in the same cycle.
// While a result waits on m_axis_tready the back end holds, the queue fills,
// and then s_axis_tready falls. Reset empties the queue and the pipeline; the
// matrix is not cleared and must be loaded before points are sent.
// ---------------------------------------------------------------------------
module point_reprojection_error #(
    parameter int COORD_BITS = pre_pkg::COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tuser: cmd
    input  logic          s_axis_tuser,
    // tdata: coeff_index[3:0], coeff_value, point_x, point_y, point_z,
    // obs_u, obs_v (196 bits, padded to 200)
    input  logic [199:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tuser: zero_w
    output logic          m_axis_tuser,
    // tdata: proj_u, proj_v, err_sq (112 bits)
    output logic [111:0]  m_axis_tdata
);
    import pre_pkg::*;
    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;

    logic fv, fr;
    t_point pt;
    logic [NCOEF*32-1:0] mat;
    logic [CW-1:0] u, v;
    logic [47:0] err;

    pre_front #(.CW(CW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tuser), .i_idx(s_axis_tdata[3:0]),
        .i_coeff(s_axis_tdata[35:4]),
        .i_x(s_axis_tdata[36 +: CW]), .i_y(s_axis_tdata[68 +: CW]),
        .i_z(s_axis_tdata[100 +: CW]), .i_ou(s_axis_tdata[132 +: CW]),
        .i_ov(s_axis_tdata[164 +: CW]),
        .o_valid(fv), .i_ready(fr), .o_pt(pt), .o_mat(mat)
    );

    pre_back #(.CW(CW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(fv), .o_ready(fr), .i_pt(pt), .i_mat(mat),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_u(u), .o_v(v), .o_err(err), .o_zw(m_axis_tuser)
    );

    assign m_axis_tdata = {err, 32'(signed'(v)), 32'(signed'(u))};
endmodule
